// File: hdl/uniform_grid_broadphase_top_defines.svh
// Assertion macros for the uniform grid broad phase.
// Included by the top level; needs nothing else.
`ifndef UNIFORM_GRID_BROADPHASE_TOP_DEFINES_SVH
`define UNIFORM_GRID_BROADPHASE_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define UGB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define UGB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ugb_pkg.sv
// Types and codes for the uniform grid broad phase.
// No dependencies.
package ugb_pkg;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_NO_OVLP = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        REG_ORIGIN_X  = 3'd0,
        REG_ORIGIN_Y  = 3'd1,
        REG_BOUNDS_W  = 3'd2,
        REG_BOUNDS_H  = 3'd3,
        REG_TILE_W    = 3'd4,
        REG_TILE_H    = 3'd5,
        REG_COL_COUNT = 3'd6,
        REG_ROW_COUNT = 3'd7
    } reg_idx_t;

    localparam int APB_AW = 5;

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_CHECK    = 14'b00000000000010,
        S_DIV_LOAD = 14'b00000000000100,
        S_DIV_RUN  = 14'b00000000001000,
        S_DIV_STORE= 14'b00000000010000,
        S_RANGE    = 14'b00000000100000,
        S_ADD_WR   = 14'b00000001000000,
        S_ADD_TAG  = 14'b00000010000000,
        S_Q_RD     = 14'b00000100000000,
        S_Q_CHK    = 14'b00001000000000,
        S_Q_TAG    = 14'b00010000000000,
        S_Q_OUT    = 14'b00100000000000,
        S_Q_END    = 14'b01000000000000,
        S_OUT_WAIT = 14'b10000000000000
    } state_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] box_x;
        logic signed [31:0] box_y;
        logic [30:0]        box_width;
        logic [30:0]        box_height;
        logic [15:0]        body_tag;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit_valid;
        logic [15:0] query_tag;
        logic [15:0] hit_tag;
        logic [6:0]  slot;
        logic        last;
    } out_t;

endpackage

// File: hdl/uniform_grid_broadphase_top.sv
// Uniform grid broad phase: tile marking, tile query and grid clear.
// Uses ugb_pkg and uniform_grid_broadphase_top_defines.svh.
//
// One transaction at a time. An add or query first runs four 32-step
// divisions (box edges over tile size) through one shared restoring
// divider, then walks its tile range: an add writes one tile per cycle,
// a query reads each tile's slot and, for an occupied tile, its tag, and
// waits for each hit result to be taken. Clear and transactions that miss
// the grid finish without the divisions; a range or slots-full rejection
// comes after the divisions. Tile occupancy is held by per-tile valid
// bits, so reset and clear take effect at once.
`include "uniform_grid_broadphase_top_defines.svh"

module uniform_grid_broadphase_top #(
    parameter int MAX_COLS   = 8,
    parameter int MAX_ROWS   = 8,
    parameter int SLOT_COUNT = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  ugb_pkg::in_t              s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output ugb_pkg::out_t             m_data,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ugb_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import ugb_pkg::*;

    localparam int NT  = MAX_COLS * MAX_ROWS;
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int AW  = (NT > 1) ? $clog2(NT) : 1;
    localparam int SW  = $clog2(SLOT_COUNT + 1);
    localparam int NW  = $clog2(SLOT_COUNT + 2);
    localparam int TIW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic signed [31:0] origin_x_reg, origin_y_reg;
    logic [30:0] bounds_w_reg, bounds_h_reg, tile_w_reg, tile_h_reg;
    logic [3:0]  col_count_reg, row_count_reg;

    state_t state_reg;
    in_t    in_reg;
    out_t   out_reg;
    logic   out_valid_reg;

    logic signed [33:0] rx0_reg, ry0_reg, rx1_reg, ry1_reg;
    logic [1:0]  div_sel_reg;
    logic [4:0]  div_cnt_reg;
    logic [30:0] div_rem_reg;
    logic [31:0] div_quo_reg;
    logic [31:0] c0_reg, r0_reg;
    logic [32:0] c1_reg, r1_reg;

    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [NT-1:0] tile_vld_reg;
    logic          tile_v_reg;
    logic          walk_done_reg;
    logic [NW-1:0] next_slot_reg;

    logic [SW-1:0] cur_slot_reg, pend_slot_reg;
    logic [15:0]   pend_tag_reg;
    logic          pend_valid_reg;

    logic [SW-1:0] tile_mem [NT];
    logic [15:0]   tag_mem [SLOT_COUNT];
    logic [SW-1:0] tile_rd_reg;
    logic [15:0]   tag_rd_reg;

    logic          cfg_we;
    logic [2:0]    cfg_idx;
    logic signed [33:0] bx, by, ox, oy, bw, bh, gw, gh, rx0, ry0;
    logic          overlap;
    logic [30:0]   tw_eff, th_eff, divisor;
    logic [31:0]   shifted, dividend;
    logic [32:0]   diff;
    logic          step_bit;
    logic [30:0]   step_rem;
    logic [32:0]   q_fin;
    logic [32:0]   cols_eff, rows_eff;
    logic [AW-1:0] tile_addr;
    logic          col_last, row_last, walk_end;
    logic          tile_we, tag_we;

    function automatic out_t mk_out(logic [1:0] st, logic hv, logic [15:0] qt,
                                    logic [15:0] ht, logic [6:0] sl, logic lst);
        out_t o;
        o.status    = st;
        o.hit_valid = hv;
        o.query_tag = qt;
        o.hit_tag   = ht;
        o.slot      = sl;
        o.last      = lst;
        return o;
    endfunction

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        case (reg_idx_t'(cfg_idx))
            REG_ORIGIN_X:  prdata = origin_x_reg;
            REG_ORIGIN_Y:  prdata = origin_y_reg;
            REG_BOUNDS_W:  prdata = {1'b0, bounds_w_reg};
            REG_BOUNDS_H:  prdata = {1'b0, bounds_h_reg};
            REG_TILE_W:    prdata = {1'b0, tile_w_reg};
            REG_TILE_H:    prdata = {1'b0, tile_h_reg};
            REG_COL_COUNT: prdata = {28'd0, col_count_reg};
            REG_ROW_COUNT: prdata = {28'd0, row_count_reg};
            default:       prdata = 32'd0;
        endcase
    end

    always_comb begin
        bx  = 34'(in_reg.box_x);
        by  = 34'(in_reg.box_y);
        ox  = 34'(origin_x_reg);
        oy  = 34'(origin_y_reg);
        bw  = $signed({3'b000, in_reg.box_width});
        bh  = $signed({3'b000, in_reg.box_height});
        gw  = $signed({3'b000, bounds_w_reg});
        gh  = $signed({3'b000, bounds_h_reg});
        overlap = (bx <= ox + gw) && (bx + bw >= ox) && (by <= oy + gh) && (by + bh >= oy);
        rx0 = bx - ox;
        ry0 = by - oy;

        tw_eff  = (tile_w_reg == 31'd0) ? 31'd1 : tile_w_reg;
        th_eff  = (tile_h_reg == 31'd0) ? 31'd1 : tile_h_reg;
        divisor = div_sel_reg[0] ? th_eff : tw_eff;
        case (div_sel_reg)
            2'd0:    dividend = rx0_reg[33] ? 32'd0 : rx0_reg[31:0];
            2'd1:    dividend = ry0_reg[33] ? 32'd0 : ry0_reg[31:0];
            2'd2:    dividend = rx1_reg[31:0];
            default: dividend = ry1_reg[31:0];
        endcase
        shifted  = {div_rem_reg, div_quo_reg[31]};
        diff     = {1'b0, shifted} - {2'b00, divisor};
        step_bit = !diff[32];
        step_rem = step_bit ? diff[30:0] : shifted[30:0];
        q_fin    = {1'b0, div_quo_reg} + 33'((div_sel_reg[1] && in_reg.operation == OP_ADD
                    && div_rem_reg != 31'd0) ? 1 : 0);

        cols_eff = (33'(col_count_reg) > 33'(MAX_COLS)) ? 33'(MAX_COLS) : 33'(col_count_reg);
        rows_eff = (33'(row_count_reg) > 33'(MAX_ROWS)) ? 33'(MAX_ROWS) : 33'(row_count_reg);

        tile_addr = AW'(row_reg) * AW'(MAX_COLS) + AW'(col_reg);
        col_last  = (col_reg == c1_reg[CW-1:0]);
        row_last  = (row_reg == r1_reg[RW-1:0]);
        walk_end  = col_last && row_last;
        tile_we   = (state_reg == S_ADD_WR);
        tag_we    = (state_reg == S_ADD_TAG);
    end

    always_ff @(posedge aclk) begin
        if (tile_we) begin
            tile_mem[tile_addr] <= SW'(next_slot_reg);
        end
        tile_rd_reg <= tile_mem[tile_addr];
        if (tag_we) begin
            tag_mem[TIW'(next_slot_reg - NW'(1))] <= in_reg.body_tag;
        end
        tag_rd_reg <= tag_mem[TIW'(tile_rd_reg - SW'(1))];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            bounds_w_reg   <= 31'd524288;
            bounds_h_reg   <= 31'd524288;
            tile_w_reg     <= 31'd65536;
            tile_h_reg     <= 31'd65536;
            col_count_reg  <= 4'd8;
            row_count_reg  <= 4'd8;
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            tile_vld_reg   <= '0;
            next_slot_reg  <= NW'(1);
            pend_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (reg_idx_t'(cfg_idx))
                    REG_ORIGIN_X:  origin_x_reg  <= pwdata;
                    REG_ORIGIN_Y:  origin_y_reg  <= pwdata;
                    REG_BOUNDS_W:  bounds_w_reg  <= pwdata[30:0];
                    REG_BOUNDS_H:  bounds_h_reg  <= pwdata[30:0];
                    REG_TILE_W:    tile_w_reg    <= pwdata[30:0];
                    REG_TILE_H:    tile_h_reg    <= pwdata[30:0];
                    REG_COL_COUNT: col_count_reg <= pwdata[3:0];
                    REG_ROW_COUNT: row_count_reg <= pwdata[3:0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        in_reg <= s_data;
                        case (op_t'(s_data.operation))
                            OP_ADD, OP_QUERY: state_reg <= S_CHECK;
                            OP_CLEAR: begin
                                tile_vld_reg  <= '0;
                                out_reg       <= mk_out(ST_OK, 1'b0, s_data.body_tag,
                                                        16'd0, 7'd0, 1'b1);
                                out_valid_reg <= 1'b1;
                                state_reg     <= S_OUT_WAIT;
                            end
                            default: begin
                                out_reg       <= mk_out(ST_OK, 1'b0, s_data.body_tag,
                                                        16'd0, 7'd0, 1'b1);
                                out_valid_reg <= 1'b1;
                                state_reg     <= S_OUT_WAIT;
                            end
                        endcase
                    end
                end
                S_CHECK: begin
                    if (!overlap) begin
                        out_reg       <= mk_out(ST_NO_OVLP, 1'b0, in_reg.body_tag,
                                                16'd0, 7'd0, 1'b1);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT_WAIT;
                    end else begin
                        rx0_reg     <= rx0;
                        ry0_reg     <= ry0;
                        rx1_reg     <= rx0 + bw;
                        ry1_reg     <= ry0 + bh;
                        div_sel_reg <= 2'd0;
                        state_reg   <= S_DIV_LOAD;
                    end
                end
                S_DIV_LOAD: begin
                    div_quo_reg <= dividend;
                    div_rem_reg <= '0;
                    div_cnt_reg <= '0;
                    state_reg   <= S_DIV_RUN;
                end
                S_DIV_RUN: begin
                    div_rem_reg <= step_rem;
                    div_quo_reg <= {div_quo_reg[30:0], step_bit};
                    div_cnt_reg <= div_cnt_reg + 5'd1;
                    if (div_cnt_reg == 5'd31) begin
                        state_reg <= S_DIV_STORE;
                    end
                end
                S_DIV_STORE: begin
                    case (div_sel_reg)
                        2'd0:    c0_reg <= div_quo_reg;
                        2'd1:    r0_reg <= div_quo_reg;
                        2'd2:    c1_reg <= q_fin;
                        default: r1_reg <= q_fin;
                    endcase
                    if (div_sel_reg == 2'd3) begin
                        state_reg <= S_RANGE;
                    end else begin
                        div_sel_reg <= div_sel_reg + 2'd1;
                        state_reg   <= S_DIV_LOAD;
                    end
                end
                S_RANGE: begin
                    if (c1_reg >= cols_eff || r1_reg >= rows_eff) begin
                        out_reg       <= mk_out(ST_RANGE, 1'b0, in_reg.body_tag,
                                                16'd0, 7'd0, 1'b1);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT_WAIT;
                    end else if (in_reg.operation == OP_ADD &&
                                 32'(next_slot_reg) > 32'(SLOT_COUNT)) begin
                        out_reg       <= mk_out(ST_FULL, 1'b0, in_reg.body_tag,
                                                16'd0, 7'd0, 1'b1);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT_WAIT;
                    end else begin
                        col_reg        <= c0_reg[CW-1:0];
                        row_reg        <= r0_reg[RW-1:0];
                        pend_valid_reg <= 1'b0;
                        state_reg      <= (in_reg.operation == OP_ADD) ? S_ADD_WR : S_Q_RD;
                    end
                end
                S_ADD_WR: begin
                    tile_vld_reg[tile_addr] <= 1'b1;
                    if (walk_end) begin
                        state_reg <= S_ADD_TAG;
                    end else if (col_last) begin
                        col_reg <= c0_reg[CW-1:0];
                        row_reg <= row_reg + RW'(1);
                    end else begin
                        col_reg <= col_reg + CW'(1);
                    end
                end
                S_ADD_TAG: begin
                    out_reg       <= mk_out(ST_OK, 1'b0, in_reg.body_tag, 16'd0,
                                            7'(next_slot_reg), 1'b1);
                    out_valid_reg <= 1'b1;
                    next_slot_reg <= next_slot_reg + NW'(1);
                    state_reg     <= S_OUT_WAIT;
                end
                S_Q_RD: begin
                    tile_v_reg <= tile_vld_reg[tile_addr];
                    state_reg  <= S_Q_CHK;
                end
                S_Q_CHK: begin
                    walk_done_reg <= walk_end;
                    cur_slot_reg  <= tile_rd_reg;
                    if (!walk_end) begin
                        if (col_last) begin
                            col_reg <= c0_reg[CW-1:0];
                            row_reg <= row_reg + RW'(1);
                        end else begin
                            col_reg <= col_reg + CW'(1);
                        end
                    end
                    if (tile_v_reg && tile_rd_reg != '0) begin
                        state_reg <= S_Q_TAG;
                    end else begin
                        state_reg <= walk_end ? S_Q_END : S_Q_RD;
                    end
                end
                S_Q_TAG: begin
                    pend_slot_reg  <= cur_slot_reg;
                    pend_tag_reg   <= tag_rd_reg;
                    pend_valid_reg <= 1'b1;
                    if (pend_valid_reg) begin
                        out_reg       <= mk_out(ST_OK, 1'b1, in_reg.body_tag, pend_tag_reg,
                                                7'(pend_slot_reg), 1'b0);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_Q_OUT;
                    end else begin
                        state_reg <= walk_done_reg ? S_Q_END : S_Q_RD;
                    end
                end
                S_Q_OUT: begin
                    if (m_ready) begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= walk_done_reg ? S_Q_END : S_Q_RD;
                    end
                end
                S_Q_END: begin
                    if (pend_valid_reg) begin
                        out_reg <= mk_out(ST_OK, 1'b1, in_reg.body_tag, pend_tag_reg,
                                          7'(pend_slot_reg), 1'b1);
                    end else begin
                        out_reg <= mk_out(ST_OK, 1'b0, in_reg.body_tag, 16'd0,
                                          7'd0, 1'b1);
                    end
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT_WAIT;
                end
                S_OUT_WAIT: begin
                    if (m_ready) begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `UGB_ASSERT_NOW(a_busy_when_out, aclk, aresetn, m_valid, !s_ready, "result pending while ready")
    `UGB_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_valid && s_ready, !s_ready, "input not held off")
    `UGB_ASSERT_NOW(a_slot_bound, aclk, aresetn, 1'b1, 32'(next_slot_reg) <= 32'(SLOT_COUNT) + 32'd1, "slot counter overran")
    `UGB_ASSERT_NEXT(a_last_ends, aclk, aresetn, m_valid && m_ready && m_data.last, s_ready, "transaction not closed after last result")

endmodule
